// ===== src/mest_pkg.sv =====
// Package for the tick-driven event sequencer: sizes, codes and the structs
// passed between the top level, the sequencer core and the event table RAM.
// No dependencies.
`default_nettype none
package mest_pkg;

	localparam int MAX_EVENTS = 4096;
	localparam int ADDR_W = $clog2(MAX_EVENTS);
	localparam int POS_W = 13;
	localparam int COUNT_W = 13;
	localparam int IDX_W = 12;
	localparam int FUNC_W = 3;
	localparam int DELTA_W = 32;
	localparam int STEP_W = 32;
	localparam int FRAC_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK  = 3'd0,
		FUNC_LOAD  = 3'd1,
		FUNC_PLAY  = 3'd2,
		FUNC_PAUSE = 3'd3,
		FUNC_STOP  = 3'd4
	} func_t;

	typedef enum logic [2:0] {
		RUN_STOP  = 3'b001,
		RUN_PLAY  = 3'b010,
		RUN_PAUSE = 3'b100
	} run_t;

	localparam logic [CFG_IDX_W-1:0] CFG_EVENT_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAY_ONCE    = 2'd2;

	typedef struct packed {
		logic [COUNT_W-1:0] event_count;
		logic [STEP_W-1:0]  default_step;
		logic               play_once;
	} cfg_t;

	typedef struct packed {
		func_t              func;
		logic [IDX_W-1:0]   entry_index;
		logic [DELTA_W-1:0] entry_delta;
		logic               entry_is_tempo;
		logic               entry_is_end;
		logic [STEP_W-1:0]  entry_step;
	} item_t;

	typedef struct packed {
		logic [DELTA_W-1:0] delta;
		logic               is_tempo;
		logic               is_end;
		logic [STEP_W-1:0]  step;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic               fire;
		logic [IDX_W-1:0]   fire_index;
		logic               all_notes_off;
		logic               playing;
		logic               paused;
		logic               ended;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		entry_t            data;
	} ram_wr_t;

endpackage
`default_nettype wire

// ===== src/mest_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module mest_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== src/mest_core.sv =====
// Sequencer core: run state, time accumulator, elapsed ticks, time step and
// event position, updated once per processed word from the event table entry.
// Depends on mest_pkg.
`default_nettype none
module mest_core (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    proc,
	input  wire mest_pkg::item_t         item,
	input  wire mest_pkg::entry_t        entry,
	input  wire mest_pkg::cfg_t          cfg,
	output mest_pkg::result_t            res,
	output mest_pkg::ram_wr_t            wr,
	output logic [mest_pkg::ADDR_W-1:0]  rd_addr
);
	import mest_pkg::*;

	run_t               run_q, run_n;
	logic               rewound_q, rewound_n;
	logic [FRAC_W-1:0]  frac_q, frac_n;
	logic [DELTA_W-1:0] elapsed_q, elapsed_n;
	logic [STEP_W-1:0]  step_q, step_n;
	logic [POS_W-1:0]   pos_q, pos_n;

	logic               at_end;
	logic [STEP_W:0]    sum;
	logic [DELTA_W-1:0] new_elapsed;
	logic               hit;
	logic [POS_W-1:0]   fire_pos;

	assign rd_addr = pos_q[ADDR_W-1:0];

	assign at_end = (pos_q >= cfg.event_count) || (32'(pos_q) >= 32'(MAX_EVENTS))
		|| entry.is_end;
	assign sum = {1'b0, step_q} + (STEP_W + 1)'(frac_q);
	assign new_elapsed = elapsed_q + DELTA_W'(sum[STEP_W:FRAC_W]);
	assign hit = (new_elapsed == entry.delta) || (entry.delta == '0);
	assign fire_pos = entry.is_tempo ? pos_q + POS_W'(1) : pos_q;

	always_comb begin
		run_n = run_q;
		rewound_n = rewound_q;
		frac_n = frac_q;
		elapsed_n = elapsed_q;
		step_n = step_q;
		pos_n = pos_q;
		res = '0;
		wr.we = 1'b0;
		wr.addr = item.entry_index[ADDR_W-1:0];
		wr.data.delta = item.entry_delta;
		wr.data.is_tempo = item.entry_is_tempo;
		wr.data.is_end = item.entry_is_end;
		wr.data.step = item.entry_step;
		case (item.func)
			FUNC_TICK: begin
				if (run_q == RUN_PAUSE) begin
					res.all_notes_off = 1'b1;
				end else if (run_q == RUN_PLAY) begin
					rewound_n = 1'b0;
					if (at_end) begin
						res.ended = 1'b1;
						if (cfg.play_once) begin
							run_n = RUN_STOP;
							res.all_notes_off = 1'b1;
						end
						elapsed_n = '0;
						frac_n = '0;
						pos_n = '0;
						step_n = cfg.default_step;
					end else begin
						frac_n = sum[FRAC_W-1:0];
						elapsed_n = new_elapsed;
						if (hit) begin
							elapsed_n = new_elapsed - entry.delta;
							if (entry.is_tempo) begin
								step_n = entry.step;
							end
							res.fire = 1'b1;
							res.fire_index = fire_pos[IDX_W-1:0];
							pos_n = fire_pos + POS_W'(1);
						end
					end
				end else if (!rewound_q) begin
					rewound_n = 1'b1;
					elapsed_n = '0;
					frac_n = '0;
					pos_n = '0;
					step_n = cfg.default_step;
				end
			end
			FUNC_LOAD: begin
				wr.we = 32'(item.entry_index) < 32'(MAX_EVENTS);
			end
			FUNC_PLAY: begin
				if (run_q != RUN_PLAY) begin
					run_n = RUN_PLAY;
				end
			end
			FUNC_PAUSE: begin
				if (run_q == RUN_PLAY) begin
					run_n = RUN_PAUSE;
					res.all_notes_off = 1'b1;
				end else if (run_q == RUN_PAUSE) begin
					run_n = RUN_PLAY;
				end
			end
			FUNC_STOP: begin
				run_n = RUN_STOP;
				res.all_notes_off = 1'b1;
			end
			default: begin
			end
		endcase
		res.playing = (run_n == RUN_PLAY);
		res.paused = (run_n == RUN_PAUSE);
		wr.we = wr.we && proc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= RUN_STOP;
			rewound_q <= 1'b0;
			frac_q <= '0;
			elapsed_q <= '0;
			step_q <= '0;
			pos_q <= '0;
		end else if (proc) begin
			run_q <= run_n;
			rewound_q <= rewound_n;
			frac_q <= frac_n;
			elapsed_q <= elapsed_n;
			step_q <= step_n;
			pos_q <= pos_n;
		end
	end

endmodule
`default_nettype wire

// ===== src/midi_event_sequencer_tick_unit.sv =====
// Top level of the tick-driven event sequencer: stream ports, configuration
// registers, input stage, event table RAM and output register.
// Depends on mest_pkg, mest_ram and mest_core.
//
// Usage: each input word carries a function code in s_axis_tuser (tick, load
// table entry, play, pause or resume, stop) and the entry fields in
// s_axis_tdata. Every input word yields exactly one output word on m_axis
// with the fire flag and index, the all-notes-off request, the run flags and
// the end flag. Configuration registers are written through cfg_we,
// cfg_index and cfg_data while the block is idle.
// Each accepted word is held in the input stage and processed once the event
// table read at the current position is ready and the output register is
// free; its result is then registered in the output register. Words are not
// processed back to back: after each processed word the event table is read
// again at the new position before the next word may use it.
// A new word is accepted while a result still waits on m_axis; when the
// receiver stalls, the input stage holds one word and then deasserts
// s_axis_tready until the output register drains.
// Reset clears the run state, time and position and returns the configuration
// registers to their defaults; the event table is undefined until loaded.
`default_nettype none
module midi_event_sequencer_tick_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// entry_index, entry_delta, entry_is_tempo, entry_is_end, entry_step, zero fill
	input  wire logic [79:0]                       s_axis_tdata,
	// func
	input  wire logic [mest_pkg::FUNC_W-1:0]       s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// fire, fire_index, all_notes_off, playing, paused, ended, zero fill
	output logic [23:0]                            m_axis_tdata,
	input  wire logic                              cfg_we,
	input  wire logic [mest_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mest_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mest_pkg::*;

	cfg_t        cfg_q;
	item_t       item_in;
	item_t       item_s1;
	logic        valid_s1;
	logic        rd_ok_q;
	logic        proc;
	result_t     res;
	result_t     out_q;
	logic        out_valid_q;
	ram_wr_t     wr;
	logic [ADDR_W-1:0] rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	entry_t      entry;

	assign item_in.func = func_t'(s_axis_tuser);
	assign item_in.entry_index = s_axis_tdata[11:0];
	assign item_in.entry_delta = s_axis_tdata[43:12];
	assign item_in.entry_is_tempo = s_axis_tdata[44];
	assign item_in.entry_is_end = s_axis_tdata[45];
	assign item_in.entry_step = s_axis_tdata[77:46];

	assign proc = valid_s1 && rd_ok_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.event_count <= '0;
			cfg_q.default_step <= '0;
			cfg_q.play_once <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EVENT_COUNT: cfg_q.event_count <= cfg_data[COUNT_W-1:0];
				CFG_DEFAULT_STEP: cfg_q.default_step <= cfg_data[STEP_W-1:0];
				CFG_PLAY_ONCE: cfg_q.play_once <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rd_ok_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			rd_ok_q <= !proc;
			if (proc) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_in;
		end
		if (proc) begin
			out_q <= res;
		end
	end

	mest_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_EVENTS)
	) u_table (
		.clk  (clk),
		.we   (wr.we),
		.waddr(wr.addr),
		.wdata(wr.data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign entry = entry_t'(rd_data);

	mest_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.proc   (proc),
		.item   (item_s1),
		.entry  (entry),
		.cfg    (cfg_q),
		.res    (res),
		.wr     (wr),
		.rd_addr(rd_addr)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {7'd0, out_q.ended, out_q.paused, out_q.playing,
		out_q.all_notes_off, out_q.fire_index, out_q.fire};

	// The table read must be redone after every update before the next word uses it.
	a_one_per_read: assert property (@(posedge clk) disable iff (!arst_n)
		proc |=> !proc) else $error("two words processed on one table read");

	a_fire_while_playing: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.fire) |-> (out_q.playing && !out_q.paused))
		else $error("event fired while not playing");

	a_fire_excl_notes_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.fire && out_q.all_notes_off))
		else $error("fire and all-notes-off raised together");

	a_end_stop_notes_off: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.ended && !out_q.playing) |-> out_q.all_notes_off)
		else $error("stop at sequence end without all-notes-off");

	a_stall_holds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q))
		else $error("input stalled without a pending word");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for midi_event_sequencer_tick_unit: drives command and table-load words
// with random gaps and stalls, and checks every result word against a scoreboard.
// Depends on mest_pkg and the RTL of the block.
`timescale 1ns / 1ps

import mest_pkg::*;

class seq_scoreboard;
	bit                 playing;
	bit                 paused;
	bit                 rewound;
	bit [FRAC_W-1:0]    frac_acc;
	bit [31:0]          elapsed;
	bit [STEP_W-1:0]    cur_step;
	bit [POS_W-1:0]     pos;
	bit [DELTA_W-1:0]   delta_tab [MAX_EVENTS];
	bit                 tempo_tab [MAX_EVENTS];
	bit                 end_tab [MAX_EVENTS];
	bit [STEP_W-1:0]    step_tab [MAX_EVENTS];
	bit [COUNT_W-1:0]   event_count;
	bit [STEP_W-1:0]    default_step;
	bit                 play_once = 1'b1;
	result_t            expected_results [$];
	int                 errors;

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_EVENT_COUNT:  event_count = val[COUNT_W-1:0];
			CFG_DEFAULT_STEP: default_step = val;
			CFG_PLAY_ONCE:    play_once = val[0];
			default: ;
		endcase
	endfunction

	function void rewind_time();
		elapsed = '0;
		frac_acc = '0;
		pos = '0;
		cur_step = default_step;
	endfunction

	function void note_word(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx, entry_t e);
		result_t r;
		bit [32:0] sum;
		bit [DELTA_W-1:0] d;
		int p;
		r = '0;
		case (f)
			FUNC_TICK: begin
				if (paused) begin
					r.all_notes_off = 1'b1;
				end else if (playing) begin
					rewound = 1'b0;
					p = int'(pos[ADDR_W-1:0]);
					if (pos >= event_count || pos >= MAX_EVENTS || end_tab[p]) begin
						r.ended = 1'b1;
						paused = 1'b0;
						if (play_once) begin
							playing = 1'b0;
							r.all_notes_off = 1'b1;
						end else begin
							playing = 1'b1;
						end
						rewind_time();
					end else begin
						sum = {17'd0, frac_acc} + {1'b0, cur_step};
						d = delta_tab[p];
						frac_acc = sum[15:0];
						elapsed = elapsed + {15'd0, sum[32:16]};
						if (elapsed == d || d == '0) begin
							elapsed = elapsed - d;
							if (tempo_tab[p]) begin
								cur_step = step_tab[p];
								pos = pos + 1'b1;
							end
							r.fire = 1'b1;
							r.fire_index = pos[IDX_W-1:0];
							pos = pos + 1'b1;
						end
					end
				end else if (!rewound) begin
					rewound = 1'b1;
					rewind_time();
				end
			end
			FUNC_LOAD: begin
				delta_tab[idx] = e.delta;
				tempo_tab[idx] = e.is_tempo;
				end_tab[idx] = e.is_end;
				step_tab[idx] = e.step;
			end
			FUNC_PLAY: begin
				if (!playing) begin
					paused = 1'b0;
					playing = 1'b1;
				end
			end
			FUNC_PAUSE: begin
				if (playing && !paused) begin
					playing = 1'b0;
					paused = 1'b1;
					r.all_notes_off = 1'b1;
				end else if (!playing && paused) begin
					paused = 1'b0;
					playing = 1'b1;
				end
			end
			FUNC_STOP: begin
				playing = 1'b0;
				paused = 1'b0;
				r.all_notes_off = 1'b1;
			end
			default: ;
		endcase
		r.playing = playing;
		r.paused = paused;
		expected_results.push_back(r);
	endfunction

	function void compare_field(string name, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	function void check_word(logic [23:0] d);
		result_t want;
		if (expected_results.size() == 0) begin
			$error("result word 0x%h arrived with no word outstanding", d);
			errors++;
			return;
		end
		want = expected_results.pop_front();
		compare_field("fire", IDX_W'(want.fire), IDX_W'(d[0]));
		compare_field("fire_index", want.fire_index, d[12:1]);
		compare_field("all_notes_off", IDX_W'(want.all_notes_off), IDX_W'(d[13]));
		compare_field("playing", IDX_W'(want.playing), IDX_W'(d[14]));
		compare_field("paused", IDX_W'(want.paused), IDX_W'(d[15]));
		compare_field("ended", IDX_W'(want.ended), IDX_W'(d[16]));
	endfunction

	function int pending();
		return expected_results.size();
	endfunction
endclass

module tb_top;
	localparam int PHASES = 8;
	localparam int RANDOM_PER_PHASE = 165;
	localparam int FUNC_CODES = 8;
	localparam int CYCLE_LIMIT = 300000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [79:0]           s_axis_tdata = '0;
	logic [FUNC_W-1:0]     s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [23:0]           m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	seq_scoreboard sb;
	int            src_idle;
	int            sink_stall;
	int            table_len;
	bit            guard_end;
	int            cycles;

	int unsigned   ph_count [PHASES] = '{8, 12, 4096, 0, 6, 4096, 16, 3};
	bit [31:0]     ph_step [PHASES] = '{32'h10000, 32'h8000, 32'h10000, 32'h0,
		32'hffffffff, 32'h18000, 32'h10000, 32'h20000};
	bit            ph_once [PHASES] = '{1, 0, 0, 1, 0, 1, 0, 1};
	int            ph_len [PHASES] = '{8, 16, 20, 4, 10, 12, 16, 5};
	bit            ph_guard [PHASES] = '{0, 0, 1, 0, 0, 1, 0, 0};
	int            idle_src [4] = '{0, 69, 0, 6};
	int            idle_sink [4] = '{0, 0, 69, 6};

	midi_event_sequencer_tick_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_word(m_axis_tdata);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic entry_t random_entry();
		entry_t e;
		e.delta = $urandom;
		e.is_tempo = 1'($urandom_range(1));
		e.is_end = 1'($urandom_range(1));
		e.step = $urandom;
		return e;
	endfunction

	// Entries inside the playable prefix keep deltas and steps small so events
	// actually fire; with a long event count the last prefix entry must end the
	// sequence and must not be skipped by a tempo entry just before it.
	function automatic entry_t table_entry(int idx);
		entry_t e;
		int pick;
		if (idx >= table_len) begin
			return random_entry();
		end
		pick = $urandom_range(99);
		e.delta = (pick < 25) ? 32'd0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(4, 8);
		e.is_tempo = ($urandom_range(99) < 20);
		e.is_end = ($urandom_range(99) < 4);
		case ($urandom_range(5))
			0: e.step = 32'h10000;
			1: e.step = 32'h8000;
			2: e.step = 32'h18000;
			3: e.step = 32'h20000;
			4: e.step = 32'h4000;
			default: e.step = $urandom_range(0, 32'h30000);
		endcase
		if (guard_end && idx == table_len - 1) begin
			e.is_end = 1'b1;
		end
		if (guard_end && idx == table_len - 2) begin
			e.is_tempo = 1'b0;
		end
		return e;
	endfunction

	task automatic send_word(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx, entry_t e);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= f;
		s_axis_tdata <= {2'b00, e.step, e.is_end, e.is_tempo, e.delta, idx};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_word(f, idx, e);
	endtask

	task automatic issue(logic [FUNC_W-1:0] f);
		send_word(f, IDX_W'($urandom), random_entry());
	endtask

	task automatic load_slot(int idx);
		send_word(FUNC_LOAD, IDX_W'(idx), table_entry(idx));
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_regs(logic [CFG_DATA_W-1:0] count, logic [CFG_DATA_W-1:0] step,
		logic [CFG_DATA_W-1:0] once);
		logic [CFG_DATA_W-1:0] vals [3];
		logic [CFG_IDX_W-1:0]  idxs [3];
		vals = '{count, step, once};
		idxs = '{CFG_EVENT_COUNT, CFG_DEFAULT_STEP, CFG_PLAY_ONCE};
		for (int i = 0; i < 3; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_reg(idxs[i], vals[i]);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_word();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			issue(FUNC_TICK);
		end else if (pick < 76) begin
			issue(FUNC_PLAY);
		end else if (pick < 80) begin
			issue(FUNC_PAUSE);
		end else if (pick < 83) begin
			issue(FUNC_STOP);
		end else if (pick < 98) begin
			if ($urandom_range(99) < 40) begin
				load_slot($urandom_range(0, table_len - 1));
			end else begin
				load_slot($urandom_range(0, MAX_EVENTS - 1));
			end
		end else begin
			issue(FUNC_W'($urandom_range(FUNC_STOP + 1, FUNC_CODES - 1)));
		end
	endtask

	initial begin
		sb = new();
		src_idle = 0;
		sink_stall = 0;
		table_len = 4;
		guard_end = 1'b0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		issue(FUNC_TICK);
		issue(FUNC_TICK);
		issue(FUNC_PAUSE);
		for (int f = FUNC_STOP + 1; f < FUNC_CODES; f++) begin
			issue(FUNC_W'(f));
		end
		send_word(FUNC_LOAD, IDX_W'(MAX_EVENTS - 1),
			'{32'hffffffff, 1'b1, 1'b1, 32'hffffffff});
		send_word(FUNC_LOAD, IDX_W'(0), '{32'd0, 1'b1, 1'b0, 32'h10000});
		send_word(FUNC_LOAD, IDX_W'(1), '{32'd2, 1'b0, 1'b0, 32'd0});
		send_word(FUNC_LOAD, IDX_W'(2), '{32'd1, 1'b0, 1'b0, 32'h8000});
		send_word(FUNC_LOAD, IDX_W'(3), '{32'd0, 1'b0, 1'b1, 32'd0});
		drain();
		write_regs(4, 32'h10000, 1);
		issue(FUNC_PLAY);
		issue(FUNC_PLAY);
		issue(FUNC_TICK);
		issue(FUNC_TICK);
		issue(FUNC_PAUSE);
		issue(FUNC_TICK);
		issue(FUNC_PAUSE);
		issue(FUNC_TICK);
		issue(FUNC_STOP);
		issue(FUNC_TICK);
		issue(FUNC_TICK);
		issue(FUNC_PLAY);
		repeat (5) issue(FUNC_TICK);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			src_idle = idle_src[p % 4];
			sink_stall = idle_sink[p % 4];
			table_len = ph_len[p];
			guard_end = ph_guard[p];
			write_regs(ph_count[p], ph_step[p], CFG_DATA_W'(ph_once[p]));
			for (int i = 0; i < table_len; i++) begin
				load_slot(i);
			end
			// A stop followed by a tick rewinds to the start of the new table.
			issue(FUNC_STOP);
			issue(FUNC_TICK);
			issue(FUNC_PLAY);
			repeat (RANDOM_PER_PHASE) random_word();
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
